@@ design/hwbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwbc_pkg
// Shared constants for the hashed window bucket counter: command codes,
// register indexes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package hwbc_pkg;

    // command codes carried in tuser
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // configuration register indexes
    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_THRESHOLD   = 1'b1;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int ITEM_W   = 16;
    localparam int SEL_W    = 7;
    localparam int CNT_W    = 16;
    localparam int WSIZE_W  = 4;
    localparam int THR_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    // reset values of the registers
    localparam logic [WSIZE_W-1:0] WSIZE_RST = 4'd2;
    localparam logic [THR_W-1:0]   THR_RST   = 16'd2;

    // hash multiplier
    localparam int HASH_MUL = 31;

    // parameter defaults
    localparam int BUCKETS_DEF    = 101;
    localparam int WINDOW_MAX_DEF = 8;
    localparam int COUNT_BITS_DEF = 16;

endpackage

@@ design/hashed_window_bucket_counter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_window_bucket_counter_top
// Counts hashed sliding-window itemsets of a transaction stream in a table
// of saturating bucket counters kept in a single-port-write memory.
//
// Usage:
//   input stream: tuser = command (clear, add, read), tdata = item and
//   bucket select, tlast = item ends its transaction (add only)
//   output stream: one transaction per read command, tdata = bucket index
//   and count, tuser = frequent flag
//   config channel: index 0 window size, index 1 report threshold; always
//   ready; the user writes it only while the block is idle (not enforced)
// Sequence:
//   read  : the bucket is read from memory at accept and the result goes
//           to the output register once free; then the next item is taken
//   add   : stays idle while the window is not full, else the HASH_A and
//           HASH_B states per window item in the shared hash/modulo unit
//           plus a bucket read and write back
//   clear : one memory entry per cycle
//   reset : a clearing pass with tready low
// A result waits in the output register while the receiver stalls; the
// block keeps taking items and holds only a read until that register frees.
// ----------------------------------------------------------------------------
module hashed_window_bucket_counter_top #(
    parameter int BUCKETS    = hwbc_pkg::BUCKETS_DEF,
    parameter int WINDOW_MAX = hwbc_pkg::WINDOW_MAX_DEF,
    parameter int COUNT_BITS = hwbc_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // item_value[15:0], bucket_select[22:16], zero [23]
    input  logic [hwbc_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // func[1:0]
    input  logic [hwbc_pkg::FUNC_W-1:0]      i_s_tuser,
    input  logic                             i_s_tlast,
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // bucket_index[6:0], bucket_count[22:7], zero [23]
    output logic [hwbc_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // is_frequent[0]
    output logic                             o_m_tuser,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hwbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hwbc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int H_BITS    = $clog2(BUCKETS);
    localparam int FILL_BITS = $clog2(WINDOW_MAX + 1);
    localparam int IDX_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int X_BITS    = $clog2((BUCKETS - 1) * hwbc_pkg::HASH_MUL
                                      + (2 ** hwbc_pkg::ITEM_W));
    localparam logic [X_BITS-1:0] RECIP = X_BITS'((64'd1 << X_BITS) / BUCKETS);
    localparam logic [X_BITS-1:0] BKT_X = X_BITS'(BUCKETS);
    localparam logic [H_BITS-1:0] LAST_BKT = H_BITS'(BUCKETS - 1);
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(WINDOW_MAX - 1);
    localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(WINDOW_MAX);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH_A = 3'd2;
    localparam logic [2:0] S_HASH_B = 3'd3;
    localparam logic [2:0] S_BKT_RD = 3'd4;
    localparam logic [2:0] S_BKT_WR = 3'd5;
    localparam logic [2:0] S_RDOUT  = 3'd6;

    logic [2:0]                        r_state;
    logic [hwbc_pkg::WSIZE_W-1:0]      r_wsize;
    logic [hwbc_pkg::THR_W-1:0]        r_thr;
    logic [FILL_BITS-1:0]              r_fill;
    logic [hwbc_pkg::ITEM_W-1:0]       r_win [WINDOW_MAX];
    logic [IDX_BITS-1:0]               r_k;
    logic [H_BITS-1:0]                 r_h;
    logic [H_BITS-1:0]                 r_clr;
    logic [X_BITS-1:0]                 r_x;
    logic [X_BITS-1:0]                 r_q;
    logic [hwbc_pkg::SEL_W-1:0]        r_sel;
    logic                              r_oor;
    logic [COUNT_BITS-1:0]             r_mem [BUCKETS];
    logic [COUNT_BITS-1:0]             r_rd_data;
    logic                              r_out_valid;
    logic [hwbc_pkg::SEL_W-1:0]        r_out_idx;
    logic [hwbc_pkg::CNT_W-1:0]        r_out_cnt;
    logic                              r_out_freq;

    logic                              s_acc;
    logic [hwbc_pkg::FUNC_W-1:0]       func;
    logic [hwbc_pkg::ITEM_W-1:0]       item;
    logic [hwbc_pkg::SEL_W-1:0]        sel;
    logic                              sel_ok;
    logic [FILL_BITS-1:0]              eff_w;
    logic [FILL_BITS-1:0]              n_fill;
    logic                              do_hash;
    logic [X_BITS-1:0]                 n_x;
    logic [2*X_BITS-1:0]               prod;
    logic [X_BITS-1:0]                 qb;
    logic [X_BITS-1:0]                 rem;
    logic [X_BITS-1:0]                 rem_c;
    logic                              out_load;
    logic                              mem_we;
    logic [H_BITS-1:0]                 mem_waddr;
    logic [COUNT_BITS-1:0]             mem_wdata;
    logic                              mem_re;
    logic [H_BITS-1:0]                 mem_raddr;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign func        = i_s_tuser;
    assign item        = i_s_tdata[hwbc_pkg::ITEM_W-1:0];
    assign sel         = i_s_tdata[hwbc_pkg::ITEM_W +: hwbc_pkg::SEL_W];
    assign sel_ok      = (32'(sel) < 32'(BUCKETS));

    // effective window size
    always_comb begin
        if (r_wsize == '0) begin
            eff_w = FILL_BITS'(1);
        end else if (32'(r_wsize) > 32'(WINDOW_MAX)) begin
            eff_w = FILL_MAX;
        end else begin
            eff_w = FILL_BITS'(r_wsize);
        end
    end

    assign n_fill  = (r_fill < FILL_MAX) ? r_fill + FILL_BITS'(1) : r_fill;
    assign do_hash = (n_fill >= eff_w);

    // hash step: x = h*31 + item, then x mod BUCKETS by reciprocal
    assign n_x   = X_BITS'(32'(r_h) * 32'(hwbc_pkg::HASH_MUL))
                   + X_BITS'(r_win[r_k]);
    assign prod  = {{X_BITS{1'b0}}, n_x} * {{X_BITS{1'b0}}, RECIP};
    assign qb    = r_q * BKT_X;
    assign rem   = r_x - qb;
    assign rem_c = (rem >= BKT_X) ? rem - BKT_X : rem;

    assign out_load = (r_state == S_RDOUT) && (!r_out_valid || i_m_tready);

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_h;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_h;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_IDLE: begin
                mem_re    = s_acc && (func == hwbc_pkg::FUNC_READ) && sel_ok;
                mem_raddr = H_BITS'(sel);
            end
            S_BKT_RD: begin
                mem_re = 1'b1;
            end
            S_BKT_WR: begin
                mem_we    = 1'b1;
                mem_wdata = (&r_rd_data) ? r_rd_data : r_rd_data + COUNT_BITS'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= hwbc_pkg::WSIZE_RST;
            r_thr   <= hwbc_pkg::THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                hwbc_pkg::CFG_WINDOW_SIZE: r_wsize <= i_cfg_data[hwbc_pkg::WSIZE_W-1:0];
                hwbc_pkg::CFG_THRESHOLD:   r_thr   <= i_cfg_data[hwbc_pkg::THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // window shift line
    always_ff @(posedge i_clk) begin
        if (s_acc && (func == hwbc_pkg::FUNC_ADD)) begin
            for (int i = 0; i < WINDOW_MAX - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW_MAX-1] <= item;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_fill  <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + H_BITS'(1);
                    if (r_clr == LAST_BKT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        unique case (func)
                            hwbc_pkg::FUNC_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLEAR;
                            end
                            hwbc_pkg::FUNC_ADD: begin
                                r_fill <= i_s_tlast ? '0 : n_fill;
                                r_h    <= '0;
                                r_k    <= IDX_BITS'(32'(WINDOW_MAX) - 32'(eff_w));
                                if (do_hash) begin
                                    r_state <= S_HASH_A;
                                end
                            end
                            hwbc_pkg::FUNC_READ: begin
                                r_sel   <= sel;
                                r_oor   <= !sel_ok;
                                r_state <= S_RDOUT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_HASH_A: begin
                    r_x     <= n_x;
                    r_q     <= prod[2*X_BITS-1:X_BITS];
                    r_state <= S_HASH_B;
                end
                S_HASH_B: begin
                    r_h <= H_BITS'(rem_c);
                    if (r_k == LAST_IDX) begin
                        r_state <= S_BKT_RD;
                    end else begin
                        r_k     <= r_k + IDX_BITS'(1);
                        r_state <= S_HASH_A;
                    end
                end
                S_BKT_RD: begin
                    r_state <= S_BKT_WR;
                end
                S_BKT_WR: begin
                    r_state <= S_IDLE;
                end
                S_RDOUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx  <= r_sel;
            r_out_cnt  <= r_oor ? '0 : hwbc_pkg::CNT_W'(r_rd_data);
            r_out_freq <= !r_oor && (32'(r_rd_data) >= 32'(r_thr));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_cnt, r_out_idx};
    assign o_m_tuser  = r_out_freq;

endmodule
